>>> hdl/tea_pkg.sv
package tea_pkg;

	localparam int unsigned ROUND_COUNT_DEF = 32;
	localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;
	localparam int unsigned SHIFT_L = 4;
	localparam int unsigned SHIFT_R = 5;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT = 3'd4;

	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} tea_key_t;

	typedef struct packed {
		logic [31:0] hi;
		logic [31:0] lo;
	} tea_blk_t;

	typedef struct packed {
		logic out_full;
		logic skid_full;
	} tea_buf_stat_t;

	// delta times a round number, modulo 2^32
	function automatic logic [31:0] sum_const(input int unsigned mult);
		logic [63:0] p;
		p = 64'(TEA_DELTA) * 64'(mult);
		return p[31:0];
	endfunction

endpackage

>>> hdl/tea_in_if.sv
interface tea_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_high;
	logic [31:0] block_low;

	modport source (output valid, output block_high, output block_low, input ready);
	modport sink (input valid, input block_high, input block_low, output ready);
endinterface

>>> hdl/tea_out_if.sv
interface tea_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_high;
	logic [31:0] out_low;

	modport source (output valid, output out_high, output out_low, input ready);
	modport sink (input valid, input out_high, input out_low, output ready);
endinterface

>>> hdl/tea_half_stage.sv
module tea_half_stage import tea_pkg::*; #(
	parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF,
	parameter int unsigned STAGE_IDX = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     dec,
	input  tea_key_t key,
	input  logic     v_in,
	input  tea_blk_t d_in,
	output logic     v_out,
	output tea_blk_t d_out
);

	localparam int unsigned ROUND = STAGE_IDX / 2;
	localparam logic SECOND = 1'((STAGE_IDX % 2) != 0);
	localparam logic [31:0] SUM_ENC = sum_const(ROUND + 1);
	localparam logic [31:0] SUM_DEC = sum_const(ROUND_COUNT - ROUND);

	logic        v_s1;
	tea_blk_t    blk_s1;
	logic        upd_hi;
	logic [31:0] src, ka, kb, sum, mix, tgt, res;
	tea_blk_t    nxt;

	always_comb begin
		// the high half is updated on the first half-round of encryption
		// and on the second half-round of decryption
		upd_hi = ~SECOND ^ dec;
		src    = upd_hi ? d_in.lo : d_in.hi;
		tgt    = upd_hi ? d_in.hi : d_in.lo;
		ka     = upd_hi ? key.k0 : key.k2;
		kb     = upd_hi ? key.k1 : key.k3;
		sum    = dec ? SUM_DEC : SUM_ENC;
		mix    = ((src << SHIFT_L) + ka) ^ (src + sum) ^ ((src >> SHIFT_R) + kb);
		res    = dec ? (tgt - mix) : (tgt + mix);
		nxt    = d_in;
		if (upd_hi) begin
			nxt.hi = res;
		end else begin
			nxt.lo = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s1 <= nxt;
		end
	end

	assign v_out = v_s1;
	assign d_out = blk_s1;

endmodule

>>> hdl/tea_out_buf.sv
module tea_out_buf import tea_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_last,
	input  tea_blk_t      d_last,
	output tea_buf_stat_t stat,
	tea_out_if.source     blk_out
);

	logic     out_v_q, skid_v_q;
	tea_blk_t out_d_q, skid_d_q;
	logic     take, incoming, load_from_skid, load_out, load_skid;

	always_comb begin
		take           = out_v_q & blk_out.ready;
		incoming       = ~skid_v_q & v_last;
		load_from_skid = skid_v_q & take;
		load_out       = incoming & (~out_v_q | take);
		load_skid      = incoming & out_v_q & ~take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_from_skid || load_out) begin
				out_v_q <= 1'b1;
			end else if (take) begin
				out_v_q <= 1'b0;
			end
			if (load_skid) begin
				skid_v_q <= 1'b1;
			end else if (load_from_skid) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			out_d_q <= skid_d_q;
		end else if (load_out) begin
			out_d_q <= d_last;
		end
		if (load_skid) begin
			skid_d_q <= d_last;
		end
	end

	assign blk_out.valid    = out_v_q;
	assign blk_out.out_high = out_d_q.hi;
	assign blk_out.out_low  = out_d_q.lo;
	assign stat.out_full    = out_v_q;
	assign stat.skid_full   = skid_v_q;

endmodule

>>> hdl/tea_block_cipher_core.sv
// TEA block cipher core, ECB, one 64-bit block per transfer. The block
// arrives as block_high (bytes 0..3, big-endian) and block_low (bytes
// 4..7) and leaves enciphered or deciphered under the 128-bit key in
// registers 0..3; register 4 selects the direction (0 encrypt, 1 decrypt).
// Every TEA cycle is unrolled into two half-round register stages, each
// holding one mix function and one add or subtract, so a new block can be
// taken every clock and a result leaves every clock while the skid is
// free and the sink keeps up. A block passes the half-round stages and
// then the output register; behind the output register sits a skid
// register. Input ready drops only while that skid is occupied, so ready
// comes straight from a flop. Write configuration only while no block is
// in flight: the stages read the key and mode registers directly.
module tea_block_cipher_core import tea_pkg::*; #(
	parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	tea_in_if.sink               blk_in,
	tea_out_if.source            blk_out
);

	localparam int unsigned STAGES = 2 * ROUND_COUNT;

	tea_key_t      key_q;
	logic          dec_q;
	tea_buf_stat_t stat;
	logic          adv;
	logic [STAGES:0] pipe_v;
	tea_blk_t      pipe_blk [STAGES+1];

	// Configuration: unknown indexes drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			dec_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_0:   key_q.k0 <= cfg_data;
				REG_KEY_1:   key_q.k1 <= cfg_data;
				REG_KEY_2:   key_q.k2 <= cfg_data;
				REG_KEY_3:   key_q.k3 <= cfg_data;
				REG_DECRYPT: dec_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance the whole pipeline unless the skid register holds a result;
	// with the skid free, the last stage always has somewhere to go.
	assign adv          = ~stat.skid_full;
	assign blk_in.ready = adv;

	assign pipe_v[0]      = blk_in.valid;
	assign pipe_blk[0].hi = blk_in.block_high;
	assign pipe_blk[0].lo = blk_in.block_low;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		tea_half_stage #(
			.ROUND_COUNT(ROUND_COUNT),
			.STAGE_IDX  (i)
		) u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.dec   (dec_q),
			.key   (key_q),
			.v_in  (pipe_v[i]),
			.d_in  (pipe_blk[i]),
			.v_out (pipe_v[i+1]),
			.d_out (pipe_blk[i+1])
		);
	end

	// Output register plus skid; hold results while the sink stalls.
	tea_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.v_last (pipe_v[STAGES]),
		.d_last (pipe_blk[STAGES]),
		.stat   (stat),
		.blk_out(blk_out)
	);

`ifndef NO_ASSERTIONS
	// The skid only fills behind a waiting output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		stat.skid_full |-> stat.out_full)
		else $error("skid occupied while output register empty");

	// An accepted block enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(blk_in.valid && blk_in.ready) |=> pipe_v[1])
		else $error("accepted block lost at pipeline entry");

	// A stall freezes every stage.
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pipe_v[STAGES:1]))
		else $error("pipeline moved during stall");
`endif

endmodule
